// ----- rtl/double_add_subtract_macros.svh -----
// ----------------------------------------------------------------------------
// double_add_subtract_macros
// Assertion macros used by the binary64 adder top level.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ADD_SUBTRACT_MACROS_SVH
`define DOUBLE_ADD_SUBTRACT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/das_pkg.sv -----
// ----------------------------------------------------------------------------
// das_pkg
// Types, constants and a helper function for the binary64 adder pipeline.
// ----------------------------------------------------------------------------
package das_pkg;

    localparam logic [63:0] SIGN_FIELD = 64'h8000_0000_0000_0000;
    localparam logic [62:0] MAX_FINITE = 63'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [5:0]  LZ_NONE    = 6'd63;

    // Alignment stage output.
    typedef struct packed {
        logic        bypass;
        logic [63:0] bypass_val;
        logic        sign;
        logic        eff_sub;
        logic [10:0] exp;
        logic [10:0] gap;
        logic [63:0] bsig;
        logic [63:0] ssig;
    } das_s1_t;

    // Add/subtract stage output.
    typedef struct packed {
        logic        bypass;
        logic [63:0] bypass_val;
        logic        sign;
        logic [10:0] exp;
        logic [63:0] sum;
    } das_s2_t;

    // Leading-zero stage output.
    typedef struct packed {
        logic               bypass;
        logic [63:0]        bypass_val;
        logic               sign;
        logic signed [12:0] exp;
        logic [63:0]        mant;
        logic [5:0]         lz;
    } das_s3_t;

    // Count of leading zeros from bit 62 down in a 63-bit word; 63 if all zero.
    function automatic logic [5:0] lzc63(input logic [62:0] v);
        logic [5:0] n;
        n = LZ_NONE;
        for (int i = 0; i < 63; i++)
        begin
            if (v[i])
            begin
                n = 6'(62 - i);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/das_align.sv -----
// ----------------------------------------------------------------------------
// das_align
// First stage: unpack, special cases, magnitude swap and exponent gap.
// ----------------------------------------------------------------------------
module das_align
    import das_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic        operation,
    input  logic [63:0] operand_x,
    input  logic [63:0] operand_y,
    output logic        s1_valid,
    output das_s1_t     s1
);

    logic    valid_reg;
    das_s1_t s1_reg;
    das_s1_t s1_next;

    // Special cases, swap and gap for the incoming request.
    always_comb
    begin
        logic [63:0] ye;
        logic [63:0] big;
        logic [63:0] sml;
        logic        xz;
        logic        yz;
        logic        x_ge;
        ye   = {operand_y[63] ^ operation, operand_y[62:0]};
        xz   = (operand_x[62:52] == 11'd0);
        yz   = (ye[62:52] == 11'd0);
        x_ge = (operand_x[62:0] >= ye[62:0]);
        big  = x_ge ? operand_x : ye;
        sml  = x_ge ? ye : operand_x;
        s1_next.bypass     = 1'b0;
        s1_next.bypass_val = 64'd0;
        if (yz)
        begin
            s1_next.bypass     = 1'b1;
            s1_next.bypass_val = xz ? (operand_x & SIGN_FIELD) : operand_x;
        end
        else if (xz)
        begin
            s1_next.bypass     = 1'b1;
            s1_next.bypass_val = ye;
        end
        else if ((operand_x[62:0] == ye[62:0]) && (operand_x[63] != ye[63]))
        begin
            s1_next.bypass     = 1'b1;
            s1_next.bypass_val = 64'd0;
        end
        s1_next.sign    = big[63];
        s1_next.eff_sub = operand_x[63] ^ ye[63];
        s1_next.exp     = big[62:52];
        s1_next.gap     = big[62:52] - sml[62:52];
        s1_next.bsig    = {2'b01, big[51:0], 10'd0};
        s1_next.ssig    = {2'b01, sml[51:0], 10'd0};
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1       = s1_reg;

endmodule

// ----- rtl/das_addsub.sv -----
// ----------------------------------------------------------------------------
// das_addsub
// Second stage: align the smaller significand and add or subtract.
// ----------------------------------------------------------------------------
module das_addsub
    import das_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    s1_valid,
    input  das_s1_t s1,
    output logic    s2_valid,
    output das_s2_t s2
);

    logic    valid_reg;
    das_s2_t s2_reg;
    das_s2_t s2_next;

    // Right shift by the gap, flushed to zero at 64 or more, then the sum or difference.
    always_comb
    begin
        logic [63:0] sh;
        sh = (s1.gap[10:6] != 5'd0) ? 64'd0 : (s1.ssig >> s1.gap[5:0]);
        s2_next.bypass     = s1.bypass;
        s2_next.bypass_val = s1.bypass_val;
        s2_next.sign       = s1.sign;
        s2_next.exp        = s1.exp;
        s2_next.sum        = s1.eff_sub ? (s1.bsig - sh) : (s1.bsig + sh);
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= s1_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2       = s2_reg;

endmodule

// ----- rtl/das_norm.sv -----
// ----------------------------------------------------------------------------
// das_norm
// Third and fourth stages: leading-zero count, normalise, pack and saturate.
// ----------------------------------------------------------------------------
module das_norm
    import das_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        s2_valid,
    input  das_s2_t     s2,
    output logic        s3_valid,
    output logic        res_valid,
    output logic [63:0] res
);

    logic        valid3_reg;
    das_s3_t     s3_reg;
    das_s3_t     s3_next;
    logic        valid4_reg;
    logic [63:0] res_reg;
    logic [63:0] res_next;

    // Carry out takes one right shift; otherwise count the leading zeros.
    always_comb
    begin
        s3_next.bypass     = s2.bypass;
        s3_next.bypass_val = s2.bypass_val;
        s3_next.sign       = s2.sign;
        if (s2.sum[63])
        begin
            s3_next.mant = s2.sum >> 1;
            s3_next.exp  = $signed({2'b00, s2.exp}) + 13'sd1;
            s3_next.lz   = 6'd0;
        end
        else
        begin
            s3_next.mant = s2.sum;
            s3_next.exp  = $signed({2'b00, s2.exp});
            s3_next.lz   = lzc63(s2.sum[62:0]);
        end
    end

    // Left shift, exponent adjust and packing with truncation.
    always_comb
    begin
        logic [63:0]        r;
        logic signed [12:0] e;
        r = s3_reg.mant << s3_reg.lz;
        e = s3_reg.exp - $signed({7'd0, s3_reg.lz});
        if (s3_reg.bypass)
        begin
            res_next = s3_reg.bypass_val;
        end
        else if ((s3_reg.mant == 64'd0) || (e < 13'sd1))
        begin
            res_next = {s3_reg.sign, 63'd0};
        end
        else if (e > 13'sd2046)
        begin
            res_next = {s3_reg.sign, MAX_FINITE};
        end
        else
        begin
            res_next = {s3_reg.sign, e[10:0], r[61:10]};
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else if (en)
        begin
            valid3_reg <= s2_valid;
            valid4_reg <= valid3_reg;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg  <= s3_next;
            res_reg <= res_next;
        end
    end

    assign s3_valid  = valid3_reg;
    assign res_valid = valid4_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/double_add_subtract.sv -----
// ----------------------------------------------------------------------------
// double_add_subtract
// Binary64 adder and subtracter with truncation, four register stages.
// ----------------------------------------------------------------------------
// One request enters every cycle while in_stall is low. The four stages are
// alignment and swap, the aligned add or subtract, the leading-zero count,
// and the normalising shift with packing. The whole pipeline holds while
// the output request is stalled, so nothing is lost.
// Zero operands (exponent field zero) pass the other operand through; the
// result is truncated and saturates to the largest finite magnitude.
`include "double_add_subtract_macros.svh"

module double_add_subtract
    import das_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] operand_x,
    input  logic [63:0] operand_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_bits
);

    logic    en;
    logic    s1_valid;
    logic    s2_valid;
    logic    s3_valid;
    das_s1_t s1;
    das_s2_t s2;

    // The pipeline moves unless a finished result is held by the consumer.
    assign in_stall = out_valid & out_stall;
    assign en       = ~in_stall;

    das_align u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .operation (operation),
        .operand_x (operand_x),
        .operand_y (operand_y),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    das_addsub u_addsub (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .s1_valid (s1_valid),
        .s1       (s1),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    das_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s2_valid  (s2_valid),
        .s2        (s2),
        .s3_valid  (s3_valid),
        .res_valid (out_valid),
        .res       (result_bits)
    );

    // Checks on the pipeline control.
    `DAS_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall, "stall without held result")
    `DAS_ASSERT_NEXT(a_enter, in_valid && !in_stall, s1_valid, "accepted request lost")
    `DAS_ASSERT_NEXT(a_drain, s3_valid && !in_stall, out_valid, "last stage lost a request")

endmodule
